// ===== rtl/core/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants of the threshold panel controller: item structs,
// opcodes, configuration register indexes and fixed scaling constants.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned FIELD_COUNT = 4;
  localparam int unsigned FIELD_W     = 2;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_LIM_W   = 8;

  typedef enum logic [2:0] {
    OP_POLL       = 3'd0,
    OP_SET_MANUAL = 3'd1,
    OP_SET_MOTOR  = 3'd2,
    OP_MIN_TEMP   = 3'd3,
    OP_MAX_TEMP   = 3'd4,
    OP_MIN_SOIL   = 3'd5,
    OP_MAX_SOIL   = 3'd6
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_CHOOSE_SHORT = 2'd1,
    CFG_UPDOWN_SHORT = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] CHOOSE_SHORT_RST = 16'd10;
  localparam logic [CFG_W-1:0] UPDOWN_SHORT_RST = 16'd5;

  // button bit positions in the level vector
  localparam int unsigned BTN_CHOOSE = 0;
  localparam int unsigned BTN_UP     = 1;
  localparam int unsigned BTN_DOWN   = 2;
  localparam int unsigned BTN_COUNT  = 3;

  localparam logic signed [11:0] TEMP_COLD = -12'sd1600;
  localparam logic [6:0]  SOIL_SCALE   = 7'd100;
  localparam logic [11:0] SOIL_DIV     = 12'd4095;
  localparam logic [6:0]  SOIL_PCT_MAX = 7'd100;

  typedef struct packed {
    op_t                opcode;
    logic signed [15:0] set_value;
    logic [15:0]        time_ms;
    logic               choose_level;
    logic               up_level;
    logic               down_level;
    logic signed [11:0] temp_sample;
    logic [11:0]        soil_adc;
  } in_item_t;

  typedef struct packed {
    logic                          relay_drive;
    logic                          temp_warning;
    logic                          soil_warning;
    logic                          manual_on;
    logic                          setup_on;
    logic [FIELD_W-1:0]            field_selected;
    logic signed [OUT_LIM_W-1:0]   temp_low_limit;
    logic signed [OUT_LIM_W-1:0]   temp_high_limit;
    logic signed [OUT_LIM_W-1:0]   soil_low_limit;
    logic signed [OUT_LIM_W-1:0]   soil_high_limit;
    logic                          limits_changed;
    logic                          manual_changed;
  } out_item_t;

endpackage

// ===== rtl/core/threshold_panel_controller_unit.sv =====
// ----------------------------------------------------------------------------
// threshold_panel_controller_unit
// Button press timing, setup/manual control, threshold limits and sensor
// warnings of a panel controller, one item out for each item in.
// ----------------------------------------------------------------------------
// Path: input register, then result register; all update logic sits
//   between them.
// Throughput: one item per cycle; the input register is refilled while a
//   result waits, so only a stalled result stalls the input side.
// Reset: synchronous active-low; buttons released, stamps and limits zero,
//   motor on, config registers at 2000/10/5 ms.
module threshold_panel_controller_unit #(
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned LIMIT_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tpc_pkg::in_item_t                    in_item,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tpc_pkg::out_item_t                   out_item,

  input  logic                                 cfg_wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpc_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int unsigned CMP_W = (TIME_BITS > tpc_pkg::CFG_W) ? TIME_BITS : tpc_pkg::CFG_W;
  localparam int unsigned TW    = LIMIT_BITS + 5;
  localparam int unsigned SW    = LIMIT_BITS + 1;
  localparam int LIM_MAX_I = (1 << (LIMIT_BITS - 1)) - 1;
  localparam int LIM_MIN_I = -LIM_MAX_I - 1;
  localparam logic signed [LIMIT_BITS-1:0] LIM_MAX = LIMIT_BITS'(LIM_MAX_I);
  localparam logic signed [LIMIT_BITS-1:0] LIM_MIN = LIMIT_BITS'(LIM_MIN_I);

  // configuration
  logic [tpc_pkg::CFG_W-1:0] long_press_r, choose_short_r, updown_short_r;

  // stage registers
  logic                in_valid_r;
  tpc_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  tpc_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                adv;

  // controller state
  logic [tpc_pkg::BTN_COUNT-1:0]    prev_r, prev_nxt;
  logic [TIME_BITS-1:0]             stamp_r   [tpc_pkg::BTN_COUNT];
  logic [TIME_BITS-1:0]             stamp_nxt [tpc_pkg::BTN_COUNT];
  logic                             setup_r, setup_nxt;
  logic [tpc_pkg::FIELD_W-1:0]      field_r, field_nxt;
  logic                             manual_r, manual_nxt;
  logic                             motor_r, motor_nxt;
  logic signed [LIMIT_BITS-1:0]     lim_r   [tpc_pkg::FIELD_COUNT];
  logic signed [LIMIT_BITS-1:0]     lim_nxt [tpc_pkg::FIELD_COUNT];

  logic [6:0] soil_pct;

  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= tpc_pkg::LONG_PRESS_RST;
      choose_short_r <= tpc_pkg::CHOOSE_SHORT_RST;
      updown_short_r <= tpc_pkg::UPDOWN_SHORT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpc_pkg::CFG_LONG_PRESS:   long_press_r   <= cfg_wdata;
        tpc_pkg::CFG_CHOOSE_SHORT: choose_short_r <= cfg_wdata;
        tpc_pkg::CFG_UPDOWN_SHORT: updown_short_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (!out_valid_r || !out_stall) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
    if (adv) out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '1;
      setup_r  <= 1'b0;
      field_r  <= '0;
      manual_r <= 1'b0;
      motor_r  <= 1'b1;
      for (int i = 0; i < tpc_pkg::BTN_COUNT; i++) stamp_r[i] <= '0;
      for (int i = 0; i < tpc_pkg::FIELD_COUNT; i++) lim_r[i] <= '0;
    end else if (adv) begin
      prev_r   <= prev_nxt;
      setup_r  <= setup_nxt;
      field_r  <= field_nxt;
      manual_r <= manual_nxt;
      motor_r  <= motor_nxt;
      for (int i = 0; i < tpc_pkg::BTN_COUNT; i++) stamp_r[i] <= stamp_nxt[i];
      for (int i = 0; i < tpc_pkg::FIELD_COUNT; i++) lim_r[i] <= lim_nxt[i];
    end
  end

  // soil percent = adc*100/4095: estimate by /4096, then one correction step
  logic [18:0] soil_prod;
  logic [18:0] soil_rem;
  logic [6:0]  soil_q0;

  always_comb begin
    soil_prod = 19'(in_item_r.soil_adc) * 19'(tpc_pkg::SOIL_SCALE);
    soil_q0   = soil_prod[18:12];
    soil_rem  = soil_prod - {soil_q0, 12'b0} + 19'(soil_q0);
    soil_pct  = (soil_rem >= 19'(tpc_pkg::SOIL_DIV)) ? soil_q0 + 7'd1 : soil_q0;
  end

  logic [tpc_pkg::BTN_COUNT-1:0] lvl, rel;
  logic [TIME_BITS-1:0]          now;
  logic [CMP_W-1:0]              dur [tpc_pkg::BTN_COUNT];
  logic [CMP_W-1:0]              long_x, choose_x, updown_x;
  logic signed [LIMIT_BITS-1:0]  cur, sat_val;
  logic [tpc_pkg::FIELD_W-1:0]   wr_idx;
  logic signed [11:0]            temp;
  logic signed [TW-1:0]          temp_x, lo_x, hi_x;
  logic signed [SW-1:0]          soil_x, slo_x, shi_x;
  logic                          lim_pulse, man_pulse, tw, sw;

  always_comb begin
    prev_nxt   = prev_r;
    setup_nxt  = setup_r;
    field_nxt  = field_r;
    manual_nxt = manual_r;
    motor_nxt  = motor_r;
    stamp_nxt  = stamp_r;
    lim_nxt    = lim_r;
    lim_pulse  = 1'b0;
    man_pulse  = 1'b0;
    rel        = '0;
    now        = TIME_BITS'(in_item_r.time_ms);
    lvl        = {in_item_r.down_level, in_item_r.up_level, in_item_r.choose_level};
    long_x     = CMP_W'(long_press_r);
    choose_x   = CMP_W'(choose_short_r);
    updown_x   = CMP_W'(updown_short_r);
    cur        = lim_r[field_r];
    wr_idx     = tpc_pkg::FIELD_W'(in_item_r.opcode - tpc_pkg::OP_MIN_TEMP);

    if (int'(in_item_r.set_value) > LIM_MAX_I) sat_val = LIM_MAX;
    else if (int'(in_item_r.set_value) < LIM_MIN_I) sat_val = LIM_MIN;
    else sat_val = LIMIT_BITS'(in_item_r.set_value);

    for (int i = 0; i < tpc_pkg::BTN_COUNT; i++) begin
      dur[i] = CMP_W'(TIME_BITS'(now - stamp_r[i]));
    end

    unique case (in_item_r.opcode) inside
      tpc_pkg::OP_POLL: begin
        for (int i = 0; i < tpc_pkg::BTN_COUNT; i++) begin
          if (prev_r[i] && !lvl[i]) stamp_nxt[i] = now;
          else if (!prev_r[i] && lvl[i]) rel[i] = 1'b1;
        end
        prev_nxt = lvl;

        if (rel[tpc_pkg::BTN_DOWN] && dur[tpc_pkg::BTN_DOWN] > updown_x) begin
          if (!manual_r) motor_nxt = !motor_r;
          if (setup_r && cur != LIM_MIN) cur = cur - LIMIT_BITS'(1);
        end

        if (rel[tpc_pkg::BTN_UP]) begin
          if (dur[tpc_pkg::BTN_UP] > long_x) begin
            manual_nxt = !manual_r;
            man_pulse  = 1'b1;
          end else if (dur[tpc_pkg::BTN_UP] > updown_x && setup_r) begin
            if (cur != LIM_MAX) cur = cur + LIMIT_BITS'(1);
          end
        end
        lim_nxt[field_r] = cur;

        if (rel[tpc_pkg::BTN_CHOOSE]) begin
          if (dur[tpc_pkg::BTN_CHOOSE] > long_x) begin
            if (!setup_r) begin
              field_nxt = '0;
              setup_nxt = 1'b1;
            end else begin
              setup_nxt = 1'b0;
              lim_pulse = 1'b1;
            end
          end else if (dur[tpc_pkg::BTN_CHOOSE] > choose_x) begin
            field_nxt = field_r + 1'b1;
          end
        end
      end
      tpc_pkg::OP_SET_MANUAL: manual_nxt = (in_item_r.set_value != '0);
      tpc_pkg::OP_SET_MOTOR:  motor_nxt  = (in_item_r.set_value != '0);
      tpc_pkg::OP_MIN_TEMP, tpc_pkg::OP_MAX_TEMP,
      tpc_pkg::OP_MIN_SOIL, tpc_pkg::OP_MAX_SOIL: lim_nxt[wr_idx] = sat_val;
      default: ;
    endcase

    // below -100 degrees the sensor reading is taken as zero
    temp   = (in_item_r.temp_sample < tpc_pkg::TEMP_COLD) ? '0 : in_item_r.temp_sample;
    temp_x = TW'(temp);
    lo_x   = TW'(lim_nxt[0]);
    hi_x   = TW'(lim_nxt[1]);
    lo_x   = lo_x <<< 4;
    hi_x   = hi_x <<< 4;
    tw     = (temp_x > hi_x) || (temp_x < lo_x);

    soil_x = signed'(SW'(soil_pct));
    slo_x  = SW'(lim_nxt[2]);
    shi_x  = SW'(lim_nxt[3]);
    sw     = (soil_x > shi_x) || (soil_x < slo_x);

    out_item_nxt.relay_drive     = motor_nxt;
    out_item_nxt.temp_warning    = tw;
    out_item_nxt.soil_warning    = sw;
    out_item_nxt.manual_on       = manual_nxt;
    out_item_nxt.setup_on        = setup_nxt;
    out_item_nxt.field_selected  = field_nxt;
    out_item_nxt.temp_low_limit  = signed'(lim_nxt[0][tpc_pkg::OUT_LIM_W-1:0]);
    out_item_nxt.temp_high_limit = signed'(lim_nxt[1][tpc_pkg::OUT_LIM_W-1:0]);
    out_item_nxt.soil_low_limit  = signed'(lim_nxt[2][tpc_pkg::OUT_LIM_W-1:0]);
    out_item_nxt.soil_high_limit = signed'(lim_nxt[3][tpc_pkg::OUT_LIM_W-1:0]);
    out_item_nxt.limits_changed  = lim_pulse;
    out_item_nxt.manual_changed  = man_pulse;
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a stalled result");

  a_leave_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.limits_changed) |-> !out_item.setup_on)
    else $error("limits pulse while still in setup");

  a_soil_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> (soil_pct <= tpc_pkg::SOIL_PCT_MAX))
    else $error("soil percent above 100");

endmodule

// ===== tb/tb_threshold_panel_controller_unit.sv =====
// ----------------------------------------------------------------------------
// tb_threshold_panel_controller_unit
// Self-checking bench for the panel controller: a queue-fed driver sends
// poll and remote-write items in random bursts, a receiver stalls on its own
// pattern (with one long hold-off), and a monitor checks every result against
// a cycle-free model of press timing, setup/manual control and warnings.
// ----------------------------------------------------------------------------
module tb_threshold_panel_controller_unit;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam logic [2:0] LV_RELEASED = 3'b111;
  localparam int LIM_HI      = 2 ** (tpc_pkg::OUT_LIM_W - 1) - 1;
  localparam int LIM_LO      = -(2 ** (tpc_pkg::OUT_LIM_W - 1));
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  tpc_pkg::in_item_t             in_item = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  tpc_pkg::out_item_t            out_item;
  logic                          cfg_wr_en = 1'b0;
  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index = tpc_pkg::CFG_LONG_PRESS;
  logic [tpc_pkg::CFG_W-1:0]     cfg_wdata = '0;

  threshold_panel_controller_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // panel model state
  logic [15:0]        long_ms = tpc_pkg::LONG_PRESS_RST;
  logic [15:0]        choose_ms = tpc_pkg::CHOOSE_SHORT_RST;
  logic [15:0]        updown_ms = tpc_pkg::UPDOWN_SHORT_RST;
  logic [2:0]         btn_levels = LV_RELEASED;
  logic [15:0]        press_ms [tpc_pkg::BTN_COUNT] = '{default: '0};
  bit                 setup_mode = 1'b0;
  logic [tpc_pkg::FIELD_W-1:0] sel_field = '0;
  bit                 manual_mode = 1'b0;
  bit                 motor_on = 1'b1;
  logic signed [tpc_pkg::OUT_LIM_W-1:0] limits [tpc_pkg::FIELD_COUNT] = '{default: '0};

  tpc_pkg::in_item_t  poll_q [$];
  tpc_pkg::out_item_t panel_due_q [$];

  logic [15:0] gen_ms = 16'd10000;
  logic [2:0]  gen_lv = LV_RELEASED;

  int fail_cnt = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_armed = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  function automatic logic signed [tpc_pkg::OUT_LIM_W-1:0] clamp_limit(input int v);
    if (v > LIM_HI) return tpc_pkg::OUT_LIM_W'(LIM_HI);
    if (v < LIM_LO) return tpc_pkg::OUT_LIM_W'(LIM_LO);
    return tpc_pkg::OUT_LIM_W'(v);
  endfunction

  // updates the stored level; returns 1 on a release with the hold time
  function automatic bit sample_button(input int idx, input logic level,
                                       input logic [15:0] now, output logic [15:0] held);
    bit rel;
    rel = 1'b0;
    held = '0;
    if (btn_levels[idx] && !level) begin
      press_ms[idx] = now;
    end else if (!btn_levels[idx] && level) begin
      held = now - press_ms[idx];
      rel = 1'b1;
    end
    btn_levels[idx] = level;
    return rel;
  endfunction

  function automatic tpc_pkg::out_item_t panel_step(input tpc_pkg::in_item_t it);
    tpc_pkg::out_item_t r;
    logic [15:0] held;
    bit rel, lim_pulse, man_pulse;
    int sv, f, tdeg, soil_pct;
    lim_pulse = 1'b0;
    man_pulse = 1'b0;
    f = sel_field;
    sv = it.set_value;
    case (it.opcode)
      tpc_pkg::OP_POLL: begin
        rel = sample_button(tpc_pkg::BTN_DOWN, it.down_level, it.time_ms, held);
        if (rel && held > updown_ms) begin
          if (!manual_mode) motor_on = !motor_on;
          if (setup_mode) limits[f] = clamp_limit(int'(limits[f]) - 1);
        end
        rel = sample_button(tpc_pkg::BTN_UP, it.up_level, it.time_ms, held);
        if (rel) begin
          if (held > long_ms) begin
            manual_mode = !manual_mode;
            man_pulse = 1'b1;
          end else if (held > updown_ms && setup_mode) begin
            limits[f] = clamp_limit(int'(limits[f]) + 1);
          end
        end
        rel = sample_button(tpc_pkg::BTN_CHOOSE, it.choose_level, it.time_ms, held);
        if (rel) begin
          if (held > long_ms) begin
            if (!setup_mode) begin
              sel_field = '0;
              setup_mode = 1'b1;
            end else begin
              setup_mode = 1'b0;
              lim_pulse = 1'b1;
            end
          end else if (held > choose_ms) begin
            sel_field = sel_field + 1'b1;
          end
        end
      end
      tpc_pkg::OP_SET_MANUAL: manual_mode = (sv != 0);
      tpc_pkg::OP_SET_MOTOR:  motor_on = (sv != 0);
      tpc_pkg::OP_MIN_TEMP:   limits[0] = clamp_limit(sv);
      tpc_pkg::OP_MAX_TEMP:   limits[1] = clamp_limit(sv);
      tpc_pkg::OP_MIN_SOIL:   limits[2] = clamp_limit(sv);
      tpc_pkg::OP_MAX_SOIL:   limits[3] = clamp_limit(sv);
      default: ;
    endcase

    tdeg = it.temp_sample;
    if (tdeg < int'(tpc_pkg::TEMP_COLD)) tdeg = 0;
    soil_pct = int'(it.soil_adc) * int'(tpc_pkg::SOIL_SCALE) / int'(tpc_pkg::SOIL_DIV);

    r.relay_drive     = motor_on;
    r.temp_warning    = (tdeg > int'(limits[1]) * 16) || (tdeg < int'(limits[0]) * 16);
    r.soil_warning    = (soil_pct > int'(limits[3])) || (soil_pct < int'(limits[2]));
    r.manual_on       = manual_mode;
    r.setup_on        = setup_mode;
    r.field_selected  = sel_field;
    r.temp_low_limit  = limits[0];
    r.temp_high_limit = limits[1];
    r.soil_low_limit  = limits[2];
    r.soil_high_limit = limits[3];
    r.limits_changed  = lim_pulse;
    r.manual_changed  = man_pulse;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_result(input tpc_pkg::out_item_t want,
                              input tpc_pkg::out_item_t got);
    check_field("relay_drive", want.relay_drive, got.relay_drive);
    check_field("temp_warning", want.temp_warning, got.temp_warning);
    check_field("soil_warning", want.soil_warning, got.soil_warning);
    check_field("manual_on", want.manual_on, got.manual_on);
    check_field("setup_on", want.setup_on, got.setup_on);
    check_field("field_selected", want.field_selected, got.field_selected);
    check_field("temp_low_limit", want.temp_low_limit, got.temp_low_limit);
    check_field("temp_high_limit", want.temp_high_limit, got.temp_high_limit);
    check_field("soil_low_limit", want.soil_low_limit, got.soil_low_limit);
    check_field("soil_high_limit", want.soil_high_limit, got.soil_high_limit);
    check_field("limits_changed", want.limits_changed, got.limits_changed);
    check_field("manual_changed", want.manual_changed, got.manual_changed);
  endtask

  // monitor: result check, input capture, watchdog
  always @(posedge clk) begin
    bit out_taken;
    out_taken = 1'b0;
    in_taken = 1'b0;
    if (rst_n) begin
      out_taken = out_valid && !out_stall;
      if (out_taken) begin
        if (panel_due_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          fail_cnt++;
        end else begin
          check_result(panel_due_q.pop_front(), out_item);
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) panel_due_q.push_back(panel_step(in_item));
    end
    if (in_taken || out_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (poll_q.size() != 0) begin
        in_item  <= poll_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    stall_tick++;
    if (hold_armed) begin
      hold_left = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_tick % 6) < 2);
      endcase
    end
  end

  function automatic tpc_pkg::in_item_t make_item(input logic [2:0] op, input int sv,
                                                  input logic [15:0] t,
                                                  input logic [2:0] lv,
                                                  input int temp, input int soil);
    tpc_pkg::in_item_t it;
    it.opcode       = tpc_pkg::op_t'(op);
    it.set_value    = 16'(sv);
    it.time_ms      = t;
    it.choose_level = lv[tpc_pkg::BTN_CHOOSE];
    it.up_level     = lv[tpc_pkg::BTN_UP];
    it.down_level   = lv[tpc_pkg::BTN_DOWN];
    it.temp_sample  = 12'(temp);
    it.soil_adc     = 12'(soil);
    return it;
  endfunction

  task automatic queue_item(input logic [2:0] op, input int sv, input logic [15:0] t,
                            input logic [2:0] lv);
    int temp, soil;
    case ($urandom_range(0, 7))
      0: temp = -2048;
      1: temp = 2047;
      2: temp = int'(tpc_pkg::TEMP_COLD) - int'($urandom_range(0, 1));
      default: temp = int'($urandom_range(0, 4095)) - 2048;
    endcase
    if ($urandom_range(0, 7) == 0) soil = ($urandom_range(0, 1) == 1) ? 4095 : 0;
    else soil = $urandom_range(0, 4095);
    poll_q.push_back(make_item(op, sv, t, lv, temp, soil));
    if (op == tpc_pkg::OP_POLL) gen_lv = lv;
  endtask

  task automatic remote_write();
    logic [2:0] op;
    int sv;
    op = 3'($urandom_range(tpc_pkg::OP_SET_MANUAL, OP_UNUSED));
    case ($urandom_range(0, 9))
      0: sv = int'($urandom_range(0, 65535)) - 32768;
      1: sv = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      2, 3, 4: sv = 0;
      default: sv = int'($urandom_range(0, 280)) - 140;
    endcase
    queue_item(op, sv, 16'($urandom), 3'($urandom));
  endtask

  task automatic random_polls(input int count);
    int target;
    logic [2:0] mask;
    logic [15:0] t0, thr, d;
    target = poll_q.size() + count;
    while (poll_q.size() < target) begin
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          if (gen_lv != LV_RELEASED)
            queue_item(tpc_pkg::OP_POLL, $urandom, gen_ms, LV_RELEASED);
          mask = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7))
                                              : 3'(1 << $urandom_range(0, 2));
          case ($urandom_range(0, 5))
            0: thr = long_ms;
            1: thr = choose_ms;
            2: thr = updown_ms;
            3: thr = 16'($urandom);
            4: thr = 16'($urandom_range(0, 20));
            default: thr = long_ms + 16'($urandom_range(0, 3000));
          endcase
          d = thr + 16'($urandom_range(0, 2)) - 16'd1;
          t0 = gen_ms;
          queue_item(tpc_pkg::OP_POLL, $urandom, t0, gen_lv & ~mask);
          repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0) remote_write();
            else queue_item(tpc_pkg::OP_POLL, $urandom,
                            t0 + 16'($urandom_range(0, d)), gen_lv);
          end
          queue_item(tpc_pkg::OP_POLL, $urandom, t0 + d, gen_lv | mask);
          gen_ms = t0 + d + 16'($urandom_range(1, 400));
        end
        [60:79]: remote_write();
        [80:89]: begin
          queue_item(tpc_pkg::OP_POLL, $urandom, gen_ms, gen_lv);
          gen_ms = gen_ms + 16'($urandom_range(0, 100));
        end
        default: queue_item(tpc_pkg::OP_POLL, $urandom, 16'($urandom), 3'($urandom));
      endcase
    end
  endtask

  task automatic write_reg(input tpc_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tpc_pkg::CFG_LONG_PRESS:   long_ms = val;
      tpc_pkg::CFG_CHOOSE_SHORT: choose_ms = val;
      tpc_pkg::CFG_UPDOWN_SHORT: updown_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [15:0] lp, input logic [15:0] cs,
                                input logic [15:0] us);
    write_reg(tpc_pkg::CFG_LONG_PRESS, lp);
    write_reg(tpc_pkg::CFG_CHOOSE_SHORT, cs);
    write_reg(tpc_pkg::CFG_UPDOWN_SHORT, us);
  endtask

  task automatic drain();
    while (poll_q.size() != 0 || in_valid || panel_due_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: remote writes with saturation, unused opcode, cold sensor,
    // press timing at the thresholds, wrapped timestamps, all buttons at once
    poll_q.push_back(make_item(tpc_pkg::OP_MIN_TEMP, -32768, 16'd0, LV_RELEASED, -2048, 0));
    poll_q.push_back(make_item(tpc_pkg::OP_MAX_TEMP, 32767, 16'd0, LV_RELEASED, 2047, 4095));
    poll_q.push_back(make_item(tpc_pkg::OP_MIN_SOIL, -129, 16'd0, LV_RELEASED, -1601, 40));
    poll_q.push_back(make_item(tpc_pkg::OP_MAX_SOIL, 128, 16'd0, LV_RELEASED, -1600, 41));
    poll_q.push_back(make_item(tpc_pkg::OP_SET_MANUAL, 1, 16'd65535, 3'b000, 0, 2048));
    poll_q.push_back(make_item(tpc_pkg::OP_SET_MANUAL, 0, 16'd65535, 3'b000, 16, 100));
    poll_q.push_back(make_item(tpc_pkg::OP_SET_MOTOR, 0, 16'd1, LV_RELEASED, -16, 200));
    poll_q.push_back(make_item(tpc_pkg::OP_SET_MOTOR, -32768, 16'd1, LV_RELEASED, 100, 4000));
    poll_q.push_back(make_item(OP_UNUSED, 32767, 16'd2, 3'b000, 5, 5));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd0, 3'b110, -1601, 0));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2001, LV_RELEASED, -1600, 4095));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2100, 3'b101, 0, 1000));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2106, LV_RELEASED, -2000, 1000));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2200, 3'b011, -2048, 3000));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2205, LV_RELEASED, -2047, 3000));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2300, 3'b011, 300, 50));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2306, LV_RELEASED, 2032, 50));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2400, 3'b110, 2033, 4094));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2410, LV_RELEASED, 2047, 4094));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2500, 3'b110, 0, 0));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd2511, LV_RELEASED, 0, 0));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd65535, 3'b101, 1, 1));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd100, LV_RELEASED, 1, 1));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd3000, 3'b000, 2000, 2000));
    poll_q.push_back(make_item(tpc_pkg::OP_POLL, 0, 16'd5001, LV_RELEASED, 2000, 2000));
    drain();

    set_thresholds(16'd300, 16'd40, 16'd20);
    random_polls(220);
    hold_armed = 1'b1;
    drain();

    set_thresholds(16'd0, 16'd0, 16'd0);
    random_polls(200);
    drain();

    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_polls(200);
    drain();

    set_thresholds(16'($urandom_range(0, 5000)), 16'($urandom_range(0, 100)),
                   16'($urandom_range(0, 100)));
    random_polls(220);
    drain();

    set_thresholds(16'd1, 16'hFFFF, 16'd0);
    random_polls(200);
    drain();

    set_thresholds(tpc_pkg::LONG_PRESS_RST, tpc_pkg::CHOOSE_SHORT_RST,
                   tpc_pkg::UPDOWN_SHORT_RST);
    random_polls(260);
    drain();

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
